>>> rtl/assert_macros.svh
// Assertion helpers used by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Signal never high outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/rbfk_pkg.sv
`default_nettype none
package rbfk_pkg;

  localparam int unsigned RowsDefault     = 16;
  localparam int unsigned FeaturesDefault = 4;

  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [15:0] GammaReset = 16'd3277;

  // Configuration register indexes.
  localparam logic [1:0] RegSelRow   = 2'd0;
  localparam logic [1:0] RegRowCount = 2'd1;
  localparam logic [1:0] RegGamma    = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StRef,
    StAcc,
    StMul1,
    StMul2,
    StOut
  } ctrl_state_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic clr_sum;
    logic acc;
    logic mul1;
    logic mul2;
    logic emit;
  } dp_cmd_t;

  // 2^(-k/16) in Q16, k = 0..16.
  function automatic logic [16:0] pow2_neg(input logic [4:0] k);
    logic [16:0] v;
    unique case (k)
      5'd0: v = 17'd65536;  5'd1: v = 17'd62757;  5'd2: v = 17'd60097;
      5'd3: v = 17'd57549;  5'd4: v = 17'd55109;  5'd5: v = 17'd52773;
      5'd6: v = 17'd50535;  5'd7: v = 17'd48393;  5'd8: v = 17'd46341;
      5'd9: v = 17'd44376;  5'd10: v = 17'd42495; 5'd11: v = 17'd40693;
      5'd12: v = 17'd38968; 5'd13: v = 17'd37316; 5'd14: v = 17'd35734;
      5'd15: v = 17'd34219; 5'd16: v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/rbfk_datapath.sv
`default_nettype none
module rbfk_datapath #(
  parameter int unsigned Rows     = rbfk_pkg::RowsDefault,
  parameter int unsigned Features = rbfk_pkg::FeaturesDefault,
  localparam int unsigned Depth   = Rows * Features,
  localparam int unsigned AddrW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_en_i,
  input  wire logic [AddrW-1:0]     wr_addr_i,
  input  wire logic [15:0]          wr_data_i,
  input  wire logic [AddrW-1:0]     rd_addr_i,
  input  wire logic                 ref_wr_i,
  input  wire logic [AddrW-1:0]     ref_idx_i,
  input  wire rbfk_pkg::dp_cmd_t    cmd_i,
  input  wire logic [15:0]          gamma_i,
  output logic [15:0]               kernel_o
);
  import rbfk_pkg::*;

  localparam int unsigned SumW  = 34 + $clog2(Features + 1);
  localparam int unsigned FIdxW = (Features > 1) ? $clog2(Features) : 1;

  logic [15:0] mem_q [Depth];
  logic [15:0] rd_q;
  logic [15:0] ref_q [Features];
  logic [15:0] refv_q;
  logic        ref_wr_q;
  logic [FIdxW-1:0] ref_idx_q;
  logic [FIdxW-1:0] refv_idx;
  logic [SumW-1:0] sum_q;
  logic [SumW+15:0] x_full;
  logic [47:0] x_q;
  logic [63:0] y_full;
  logic [47:0] y_q;

  // Sample memory, one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // Reference row capture: read data arrives in the cycle after the address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_wr_q <= 1'b0;
    end else begin
      ref_wr_q <= ref_wr_i;
    end
  end
  always_ff @(posedge clk_i) begin
    ref_idx_q <= ref_idx_i[FIdxW-1:0];
    if (ref_wr_q) begin
      ref_q[ref_idx_q] <= rd_q;
    end
  end

  // The reference element used in accumulation is registered and follows the read in the next cycle.
  // An element still being captured is forwarded from the read register.
  assign refv_idx = (32'(ref_idx_i) >= Features) ? '0 : ref_idx_i[FIdxW-1:0];
  always_ff @(posedge clk_i) begin
    if (ref_wr_q && (ref_idx_q == refv_idx)) begin
      refv_q <= rd_q;
    end else begin
      refv_q <= ref_q[refv_idx];
    end
  end

  logic signed [16:0] diff;
  logic [16:0] mag;
  logic [33:0] sq;
  assign diff = $signed({refv_q[15], refv_q}) - $signed({rd_q[15], rd_q});
  assign mag  = diff[16] ? 17'(-diff) : diff;
  assign sq   = 34'(mag) * 34'(mag);

  // Squared distance accumulator, one element per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_sum) begin
      sum_q <= '0;
    end else if (cmd_i.acc) begin
      sum_q <= sum_q + SumW'(sq);
    end
  end

  assign x_full = (SumW+16)'(gamma_i) * (SumW+16)'(sum_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      x_q <= 48'(x_full >> 16);
    end
  end

  assign y_full = 64'(x_q) * 64'(Log2eQ16);
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin
      y_q <= 48'(y_full >> 16);
    end
  end

  // Exponent: table interpolation and rounding shift.
  logic [31:0] n;
  logic [15:0] f;
  logic [16:0] p0, p1, v0;
  logic [29:0] prod;
  logic [17:0] v;
  logic [17:0] r;
  assign n    = y_q[47:16];
  assign f    = y_q[15:0];
  assign p0   = pow2_neg({1'b0, f[15:12]});
  assign p1   = pow2_neg(5'({1'b0, f[15:12]} + 5'd1));
  assign prod = 30'(p0 - p1) * 30'(f[11:0]);
  assign v0   = p0 - 17'(prod >> 12);
  always_comb begin
    v = 18'(v0);
    r = '0;
    if (n <= 32'd16) begin
      if (n != 32'd0) begin
        v = v + (18'd1 << (n[4:0] - 5'd1));
      end
      r = v >> n[4:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kernel_o <= (r > 18'd65535) ? 16'hFFFF : r[15:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/rbfk_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module rbfk_ctrl #(
  parameter int unsigned Rows     = rbfk_pkg::RowsDefault,
  parameter int unsigned Features = rbfk_pkg::FeaturesDefault,
  localparam int unsigned Depth   = Rows * Features,
  localparam int unsigned AddrW   = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW    = $clog2(Depth + 1),
  localparam int unsigned RowW    = $clog2(Rows + 1),
  localparam int unsigned FW      = $clog2(Features + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [3:0]        sel_row_i,
  input  wire logic [4:0]        row_count_i,
  output logic                   wr_en_o,
  output logic [AddrW-1:0]       wr_addr_o,
  output logic [AddrW-1:0]       rd_addr_o,
  output logic                   ref_wr_o,
  output logic [AddrW-1:0]       ref_idx_o,
  output rbfk_pkg::dp_cmd_t      cmd_o,
  output logic                   strobe_o,
  output logic [3:0]             row_number_o,
  output logic                   last_o
);
  import rbfk_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RowW-1:0] row_q, row_d;
  logic [FW-1:0]   j_q, j_d;
  logic [RowW-1:0] rows, refr;
  logic [CntW:0]   total;
  logic            strobe_q, strobe_d, last_q, last_d;
  logic [3:0]      rown_q, rown_d;

  // Effective row count and reference row.
  always_comb begin
    rows = (row_count_i == 5'd0) ? RowW'(1) :
           (32'(row_count_i) > Rows) ? RowW'(Rows) : RowW'(row_count_i);
    refr = (RowW'(sel_row_i) >= rows) ? rows - RowW'(1) : RowW'(sel_row_i);
    if (32'(sel_row_i) >= Rows) refr = rows - RowW'(1);
    total = (CntW+1)'(rows) * (CntW+1)'(Features);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      row_q    <= '0;
      j_q      <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      rown_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      row_q    <= row_d;
      j_q      <= j_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
      rown_q   <= rown_d;
    end
  end

  assign busy         = (state_q != StIdle);
  assign strobe_o     = strobe_q;
  assign last_o       = last_q;
  assign row_number_o = rown_q;
  assign wr_addr_o    = AddrW'(cnt_q);

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    row_d      = row_q;
    j_d        = j_q;
    strobe_d   = 1'b0;
    last_d     = last_q;
    rown_d     = rown_q;
    wr_en_o    = 1'b0;
    rd_addr_o  = '0;
    ref_wr_o   = 1'b0;
    ref_idx_o  = AddrW'(j_q);
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          wr_en_o = (32'(cnt_q) < Depth);
          if ((CntW+1)'(cnt_q) + (CntW+1)'(1) < total) begin
            cnt_d = cnt_q + CntW'(1);
          end else begin
            cnt_d   = '0;
            j_d     = '0;
            row_d   = '0;
            state_d = StRef;
          end
        end
      end
      StRef: begin
        // Fetch the reference row into the datapath, one element per cycle.
        rd_addr_o  = AddrW'((AddrW+FW+1)'(refr) * (AddrW+FW+1)'(Features)
                     + (AddrW+FW+1)'(j_q));
        ref_wr_o   = 1'b1;
        if (32'(j_q) == Features - 1) begin
          j_d     = '0;
          state_d = StAcc;
        end else begin
          j_d = j_q + FW'(1);
        end
      end
      StAcc: begin
        // j_q counts reads issued; an element is accumulated in the cycle after its read.
        rd_addr_o = AddrW'((AddrW+FW+1)'(row_q) * (AddrW+FW+1)'(Features)
                    + (AddrW+FW+1)'(j_q));
        if (j_q == '0) cmd_o.clr_sum = 1'b1;
        else cmd_o.acc = 1'b1;
        if (32'(j_q) == Features) begin
          j_d     = '0;
          state_d = StMul1;
        end else begin
          j_d = j_q + FW'(1);
        end
      end
      StMul1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = StMul2;
      end
      StMul2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = StOut;
      end
      StOut: begin
        cmd_o.emit = 1'b1;
        strobe_d   = 1'b1;
        rown_d     = 4'(row_q);
        last_d     = (row_q + RowW'(1) == rows);
        if (row_q + RowW'(1) == rows) begin
          state_d = StIdle;
        end else begin
          row_d   = row_q + RowW'(1);
          state_d = StAcc;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  `ASSERT_IMPL(a_strobe_busy, clk_i, rst_ni, !strobe_q || $past(busy), "strobe without run")
  `ASSERT_NEVER(a_wr_busy, clk_i, rst_ni, wr_en_o && busy, "store written while busy")
  `ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 32'(cnt_q) < Depth, "element count out of range")

endmodule
`default_nettype wire

>>> rtl/rbf_kernel_row_top.sv
// Load: one element per cycle while busy is low; the last element starts a run.
// Run: fetch the reference row, then per row accumulate, multiply and output.
// Results are single-cycle strobes; the receiver cannot stall.
// Reset (rst_ni low, async) clears control and config; datapath data is undefined.
`default_nettype none
module rbf_kernel_row_top #(
  parameter int unsigned Rows     = rbfk_pkg::RowsDefault,
  parameter int unsigned Features = rbfk_pkg::FeaturesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] feature_value_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  output logic                    result_valid_o,
  output logic [15:0]             kernel_value_o,
  output logic [3:0]              row_number_o,
  output logic                    last_result_o
);
  import rbfk_pkg::*;

  localparam int unsigned Depth = Rows * Features;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [3:0]  sel_q;
  logic [4:0]  cnt_q;
  logic [15:0] gamma_q;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= '0;
      cnt_q   <= 5'd16;
      gamma_q <= GammaReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegSelRow:   sel_q   <= cfg_data_i[3:0];
        RegRowCount: cnt_q   <= cfg_data_i[4:0];
        RegGamma:    gamma_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic             wr_en, ref_wr;
  logic [AddrW-1:0] wr_addr, rd_addr, ref_idx;
  dp_cmd_t          cmd;

  rbfk_ctrl #(.Rows(Rows), .Features(Features)) u_ctrl (
    .clk_i, .rst_ni, .start, .busy,
    .sel_row_i(sel_q), .row_count_i(cnt_q),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .rd_addr_o(rd_addr),
    .ref_wr_o(ref_wr), .ref_idx_o(ref_idx),
    .cmd_o(cmd), .strobe_o(result_valid_o),
    .row_number_o(row_number_o), .last_o(last_result_o)
  );

  rbfk_datapath #(.Rows(Rows), .Features(Features)) u_dp (
    .clk_i, .rst_ni,
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(feature_value_i),
    .rd_addr_i(rd_addr), .ref_wr_i(ref_wr),
    .ref_idx_i(ref_idx), .cmd_i(cmd), .gamma_i(gamma_q),
    .kernel_o(kernel_value_o)
  );

endmodule
`default_nettype wire
